// File: hdl/bscs_pkg.sv
package bscs_pkg;

  localparam int MAX_BLOCK = 8;
  localparam int VEC_DEPTH = 1024;
  localparam int VEC_AW    = $clog2(VEC_DEPTH);
  // wide enough for block_row * block_size + offset and for any length
  localparam int RC_W      = (VEC_AW + 2 > 16) ? VEC_AW + 2 : 16;
  localparam int LEN_W     = 11;
  localparam int BS_W      = 4;
  localparam int X_W       = 32;
  localparam int Y_W       = 64;

  typedef enum logic [1:0] {
    K_LOAD  = 2'd0,
    K_ENTRY = 2'd1,
    K_CLEAR = 2'd2,
    K_READ  = 2'd3
  } kind_t;

  typedef enum logic [1:0] {
    STAT_OK   = 2'd0,
    STAT_DROP = 2'd1,
    STAT_BAD  = 2'd2
  } status_t;

  typedef enum logic [1:0] {
    CFG_BLOCK_SIZE = 2'd0,
    CFG_ROWS       = 2'd1,
    CFG_COLS       = 2'd2,
    CFG_UNIT_DIAG  = 2'd3
  } cfg_idx_t;

  typedef enum logic [2:0] {
    S_IDLE,
    S_MUL,
    S_ACC,
    S_DONE,
    S_CLR
  } state_t;

  typedef struct packed {
    kind_t              kind;
    logic [9:0]         elem_index;
    logic [9:0]         block_col;
    logic [9:0]         block_row;
    logic [2:0]         row_in_block;
    logic [2:0]         col_in_block;
    logic signed [31:0] value;
  } in_item_t;

  typedef struct packed {
    logic signed [63:0] read_value;
    status_t            status;
  } out_item_t;

  // effective configuration seen by the controller
  typedef struct packed {
    logic [RC_W-1:0] bs;
    logic [RC_W-1:0] nr;
    logic [RC_W-1:0] nc;
    logic            unit_diag;
    logic            square;
  } cfg_t;

  typedef struct packed {
    logic              we;
    logic [VEC_AW-1:0] waddr;
    logic [X_W-1:0]    wdata;
    logic              re;
    logic [VEC_AW-1:0] raddr;
  } xreq_t;

  typedef struct packed {
    logic              we;
    logic [VEC_AW-1:0] waddr;
    logic [Y_W-1:0]    wdata;
    logic              re;
    logic [VEC_AW-1:0] raddr;
  } yreq_t;

  function automatic logic [RC_W-1:0] eff_bs(input logic [BS_W-1:0] b);
    logic [RC_W-1:0] r;
    if (b == '0) begin
      r = RC_W'(1);
    end else if (RC_W'(b) > RC_W'(MAX_BLOCK)) begin
      r = RC_W'(MAX_BLOCK);
    end else begin
      r = RC_W'(b);
    end
    return r;
  endfunction

  function automatic logic [RC_W-1:0] eff_len(input logic [LEN_W-1:0] v);
    logic [RC_W-1:0] r;
    if (RC_W'(v) > RC_W'(VEC_DEPTH)) begin
      r = RC_W'(VEC_DEPTH);
    end else begin
      r = RC_W'(v);
    end
    return r;
  endfunction

endpackage

// File: hdl/bscs_ram.sv
module bscs_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 1024
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

// File: hdl/bscs_ctrl.sv
module bscs_ctrl
  import bscs_pkg::*;
(
  input  logic           clk,
  input  logic           rst_n,
  input  cfg_t           cfg,
  input  logic           in_valid,
  output logic           in_stall,
  input  in_item_t       in_data,
  output logic           out_valid,
  input  logic           out_stall,
  output out_item_t      out_data,
  output xreq_t          xreq,
  input  logic [X_W-1:0] x_rdata,
  output yreq_t          yreq,
  input  logic [Y_W-1:0] y_rdata
);

  state_t state_r, state_nxt;

  status_t            st_r;
  logic               rd_sel_r;
  logic signed [31:0] val_r;
  logic [VEC_AW-1:0]  yaddr_r;
  logic signed [63:0] prod_r;
  logic               copy_r;
  logic               clr_item_r;
  logic [VEC_AW-1:0]  clr_ptr_r;
  logic               cwr_v_r;
  logic [VEC_AW-1:0]  cwr_addr_r;
  logic               cwr_cp_r;
  logic               out_valid_r;
  out_item_t          out_data_r;

  logic               acc;
  logic               out_free;
  logic [RC_W-1:0]    r_glob;
  logic [RC_W-1:0]    c_glob;
  logic               off_bad;
  logic               outside;
  logic               entry_go;
  logic               load_ok;
  logic               read_ok;
  logic               clr_last;
  status_t            st_nxt;
  logic               rd_sel_nxt;
  logic signed [63:0] prod_nxt;
  logic [Y_W-1:0]     sum;
  logic [Y_W-1:0]     sat_sum;
  logic [Y_W-1:0]     copy_val;

  assign in_stall = (state_r != S_IDLE) || cwr_v_r;
  assign acc      = in_valid && !in_stall;
  assign out_free = !out_valid_r || !out_stall;

  assign r_glob   = RC_W'(in_data.block_row) * cfg.bs + RC_W'(in_data.row_in_block);
  assign c_glob   = RC_W'(in_data.block_col) * cfg.bs + RC_W'(in_data.col_in_block);
  assign off_bad  = (RC_W'(in_data.row_in_block) >= cfg.bs) ||
                    (RC_W'(in_data.col_in_block) >= cfg.bs);
  assign outside  = (r_glob >= cfg.nr) || (c_glob >= cfg.nc);
  assign entry_go = !off_bad && !outside;
  assign load_ok  = RC_W'(in_data.elem_index) < cfg.nc;
  assign read_ok  = RC_W'(in_data.elem_index) < cfg.nr;
  assign clr_last = clr_ptr_r == VEC_AW'(VEC_DEPTH - 1);

  assign prod_nxt = val_r * $signed(x_rdata);
  assign sum      = y_rdata + prod_r;
  // saturate when both operands share a sign the sum lost
  always_comb begin
    sat_sum = sum;
    if (y_rdata[Y_W-1] == prod_r[Y_W-1] && sum[Y_W-1] != y_rdata[Y_W-1]) begin
      sat_sum = y_rdata[Y_W-1] ? {1'b1, {(Y_W-1){1'b0}}} : {1'b0, {(Y_W-1){1'b1}}};
    end
  end
  assign copy_val = cwr_cp_r ? {{16{x_rdata[X_W-1]}}, x_rdata, 16'b0} : '0;

  // status of the request being accepted
  always_comb begin
    st_nxt     = STAT_OK;
    rd_sel_nxt = 1'b0;
    case (in_data.kind)
      K_LOAD: begin
        if (!load_ok) st_nxt = STAT_BAD;
      end
      K_ENTRY: begin
        if (off_bad) st_nxt = STAT_BAD;
        else if (outside) st_nxt = STAT_DROP;
      end
      K_CLEAR: begin
        if (cfg.unit_diag && !cfg.square) st_nxt = STAT_BAD;
      end
      default: begin
        if (read_ok) rd_sel_nxt = 1'b1;
        else st_nxt = STAT_BAD;
      end
    endcase
  end

  // next state
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      S_IDLE: begin
        if (acc) begin
          case (in_data.kind)
            K_ENTRY: state_nxt = entry_go ? S_MUL : S_DONE;
            K_CLEAR: state_nxt = S_CLR;
            default: state_nxt = S_DONE;
          endcase
        end
      end
      S_MUL: state_nxt = S_ACC;
      S_ACC: begin
        if (out_free) state_nxt = S_IDLE;
      end
      S_DONE: begin
        if (out_free) state_nxt = S_IDLE;
      end
      S_CLR: begin
        if (clr_last) state_nxt = clr_item_r ? S_DONE : S_IDLE;
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  // memory requests
  always_comb begin
    xreq.we    = (state_r == S_IDLE) && acc && (in_data.kind == K_LOAD) && load_ok;
    xreq.waddr = VEC_AW'(in_data.elem_index);
    xreq.wdata = in_data.value;
    xreq.re    = ((state_r == S_IDLE) && acc && (in_data.kind == K_ENTRY) && entry_go) ||
                 (state_r == S_CLR);
    xreq.raddr = (state_r == S_CLR) ? clr_ptr_r : c_glob[VEC_AW-1:0];

    yreq.re    = (state_r == S_IDLE) && acc &&
                 (((in_data.kind == K_ENTRY) && entry_go) ||
                  ((in_data.kind == K_READ) && read_ok));
    yreq.raddr = (in_data.kind == K_READ) ? VEC_AW'(in_data.elem_index)
                                          : r_glob[VEC_AW-1:0];
    // clear sweep writes never coincide with an accumulate
    yreq.we    = cwr_v_r || ((state_r == S_ACC) && out_free);
    yreq.waddr = cwr_v_r ? cwr_addr_r : yaddr_r;
    yreq.wdata = cwr_v_r ? copy_val : sat_sum;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_CLR;
      clr_item_r  <= 1'b0;
      copy_r      <= 1'b0;
      clr_ptr_r   <= '0;
      cwr_v_r     <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r <= state_nxt;

      cwr_v_r    <= state_r == S_CLR;
      cwr_addr_r <= clr_ptr_r;
      cwr_cp_r   <= copy_r && (RC_W'(clr_ptr_r) < cfg.nr);
      if (state_r == S_CLR) begin
        clr_ptr_r <= clr_ptr_r + 1'b1;
      end else if (acc && in_data.kind == K_CLEAR) begin
        clr_ptr_r <= '0;
      end

      if (acc) begin
        val_r    <= in_data.value;
        yaddr_r  <= r_glob[VEC_AW-1:0];
        rd_sel_r <= rd_sel_nxt;
        st_r     <= st_nxt;
        if (in_data.kind == K_CLEAR) begin
          clr_item_r <= 1'b1;
          copy_r     <= cfg.unit_diag && cfg.square;
        end
      end

      if (state_r == S_MUL) begin
        prod_r <= prod_nxt;
      end

      if ((state_r == S_DONE || state_r == S_ACC) && out_free) begin
        out_valid_r <= 1'b1;
        out_data_r.read_value <= (state_r == S_DONE && rd_sel_r) ? $signed(y_rdata) : '0;
        out_data_r.status     <= (state_r == S_DONE) ? st_r : STAT_OK;
      end else if (!out_stall) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

endmodule

// File: hdl/block_sparse_column_spmv.sv
// block sparse column y = A*x engine, fixed point
// in_valid/in_stall/in_data carry one request: load x element, matrix block
// entry, clear y (copy x into y when unit_diag is set and rows == cols), or
// read y element. every request gives exactly one result on out_valid /
// out_stall / out_data (read_value in Q31.32 for reads, else zero, plus status).
// cfg_valid/cfg_index/cfg_data write block_size, rows, cols, unit_diag;
// cfg_ready is always high, write only while no request is in flight.
// timing: x load, y read and rejected requests go through S_DONE into the
// result register; the next request is taken once back in S_IDLE.
// a matrix entry steps through x and y memory read, 32x32 multiply and
// saturating add with y write back through the single y write port.
// clear sweeps all VEC_DEPTH y entries, one per cycle, then gives its result;
// in_stall is high meanwhile. after reset the same sweep zeroes y, and in_stall
// stays high until its last y write. the result register holds while out_stall
// is high, and one more request can be accepted while a result waits; its own
// result then waits too.
module block_sparse_column_spmv
  import bscs_pkg::*;
(
  input  logic             clk,
  input  logic             rst_n,
  input  logic             in_valid,
  output logic             in_stall,
  input  in_item_t         in_data,
  output logic             out_valid,
  input  logic             out_stall,
  output out_item_t        out_data,
  input  logic             cfg_valid,
  output logic             cfg_ready,
  input  cfg_idx_t         cfg_index,
  input  logic [LEN_W-1:0] cfg_data
);

  logic [BS_W-1:0]  block_size_r;
  logic [LEN_W-1:0] rows_r;
  logic [LEN_W-1:0] cols_r;
  logic             unit_diag_r;
  cfg_t             cfg;

  xreq_t            xreq;
  yreq_t            yreq;
  logic [X_W-1:0]   x_rdata;
  logic [Y_W-1:0]   y_rdata;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      block_size_r <= BS_W'(1);
      rows_r       <= LEN_W'(1024);
      cols_r       <= LEN_W'(1024);
      unit_diag_r  <= 1'b0;
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        CFG_BLOCK_SIZE: block_size_r <= cfg_data[BS_W-1:0];
        CFG_ROWS:       rows_r       <= cfg_data;
        CFG_COLS:       cols_r       <= cfg_data;
        CFG_UNIT_DIAG:  unit_diag_r  <= cfg_data[0];
        default: ;
      endcase
    end
  end

  always_comb begin
    cfg.bs        = eff_bs(block_size_r);
    cfg.nr        = eff_len(rows_r);
    cfg.nc        = eff_len(cols_r);
    cfg.unit_diag = unit_diag_r;
    cfg.square    = rows_r == cols_r;
  end

  bscs_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg       (cfg),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data),
    .xreq      (xreq),
    .x_rdata   (x_rdata),
    .yreq      (yreq),
    .y_rdata   (y_rdata)
  );

  bscs_ram #(
    .WIDTH (X_W),
    .DEPTH (VEC_DEPTH)
  ) u_x_ram (
    .clk   (clk),
    .we    (xreq.we),
    .waddr (xreq.waddr),
    .wdata (xreq.wdata),
    .re    (xreq.re),
    .raddr (xreq.raddr),
    .rdata (x_rdata)
  );

  bscs_ram #(
    .WIDTH (Y_W),
    .DEPTH (VEC_DEPTH)
  ) u_y_ram (
    .clk   (clk),
    .we    (yreq.we),
    .waddr (yreq.waddr),
    .wdata (yreq.wdata),
    .re    (yreq.re),
    .raddr (yreq.raddr),
    .rdata (y_rdata)
  );

endmodule
